@@ hw/rtl/tam_pkg.sv @@
// ----------------------------------------------------------------------------
// tam_pkg: shared widths, codes and types for the anisotropy measure
// Field widths, mode codes and the divider lane type used by the top level
// and by the restoring divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package tam_pkg;

  // Eigenvalue format: signed, FRACTION_BITS fraction bits
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;

  // Result widths
  localparam int unsigned SCALAR_WIDTH = VALUE_WIDTH + 1;
  localparam int unsigned FRAC_WIDTH   = FRACTION_BITS + 1;

  // Sum of three magnitudes and every numerator fit here
  localparam int unsigned SUM_WIDTH = VALUE_WIDTH + 2;

  // Shift-and-compare steps after the leading quotient bit
  localparam int unsigned DIV_STEPS = FRACTION_BITS;

  // Stream packing
  localparam int unsigned IN_FIELDS_W  = 3 * VALUE_WIDTH;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = SCALAR_WIDTH + 3 * FRAC_WIDTH;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Unity in Q1.F
  localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = FRAC_WIDTH'(1) << FRACTION_BITS;

  // Measure mode codes
  localparam int unsigned MODE_WIDTH = 2;
  localparam logic [MODE_WIDTH-1:0] MODE_MAJ_MID  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_MAJ_MIN  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_BARY     = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_ABS_DIFF = 2'd3;

  // One divider lane: partial remainder and quotient so far
  typedef struct packed {
    logic [SUM_WIDTH-1:0]  rem;
    logic [FRAC_WIDTH-1:0] quo;
  } tam_div_lane_t;

endpackage : tam_pkg

`default_nettype wire

@@ hw/rtl/tensor_anisotropy_measure.sv @@
// ----------------------------------------------------------------------------
// tensor_anisotropy_measure: eigenvalue anisotropy measure, one voxel a beat
//
// Input stream (s_axis_*): one beat carries a voxel's major, middle and minor
// eigenvalues, signed fixed point. Output stream (m_axis_*): one beat per
// input beat, in order, carrying the scalar measure and three barycentric
// fractions. The cfg_* channel writes the 2-bit measure mode; it is always
// ready and should only be written while no voxel is in flight.
//
// Mode 0 gives |major-middle|, mode 1 |major-minor|, mode 3 |major|-|minor|,
// mode 2 the sorted-magnitude barycentric fractions (a-b)/s, 2(b-c)/s, 3c/s.
//
// From input beat to output beat a voxel passes the input register,
// magnitudes, sort, sum and numerators, leading quotient bit, then one
// restoring divider stage per fraction bit. Throughput is one beat per cycle
// while the receiver does not stall, as the dividers are fully pipelined.
//
// Reset clears every stage valid bit and the mode to 0. A stalled receiver
// freezes the whole pipeline; s_axis_tready follows the output register
// being empty or taken, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_anisotropy_measure (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // major [31:0], middle [63:32], minor [95:64]
  input  wire logic [tam_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // scalar [32:0], linear [49:33], planar [66:50], spherical [83:67], zero pad
  output logic [tam_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [tam_pkg::MODE_WIDTH-1:0]  cfg_data_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o
);

  import tam_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;

  logic en;

  // Mode register
  logic [MODE_WIDTH-1:0] mode_q;

  // Stage 1: captured beat
  logic                  v1_q;
  logic [MODE_WIDTH-1:0] mode1_q;
  logic [VW-1:0]         maj1_q, mid1_q, min1_q;

  // Stage 2: magnitudes and scalar
  logic                    v2_q;
  logic [MODE_WIDTH-1:0]   mode2_q;
  logic [SCALAR_WIDTH-1:0] scal2_q, scal2_d;
  logic [VW-1:0]           ma2_q, mb2_q, mc2_q;
  logic [VW-1:0]           amaj, amid, amin;
  logic [SCALAR_WIDTH-1:0] d_mm, d_mn;

  // Stage 3: sorted magnitudes
  logic                    v3_q;
  logic [MODE_WIDTH-1:0]   mode3_q;
  logic [SCALAR_WIDTH-1:0] scal3_q;
  logic [VW-1:0]           sa3_q, sb3_q, sc3_q;
  logic [VW-1:0]           hi_d, lo_d, md_d;
  logic                    ge_ab, ge_bc, ge_ac;

  // Stage 4: divisor and numerators
  logic                    v4_q;
  logic [SCALAR_WIDTH-1:0] scal4_q;
  logic [SUM_WIDTH-1:0]    s4_q, s4_d;
  logic [SUM_WIDTH-1:0]    num4_q [3];
  logic [SUM_WIDTH-1:0]    num4_d [3];

  // Stage 5: leading quotient bit
  logic                    v5_q;
  logic [SCALAR_WIDTH-1:0] scal5_q;
  logic [SUM_WIDTH-1:0]    den5_q;
  tam_div_lane_t           lane5_q [3];
  tam_div_lane_t           lane5_d [3];

  // Divider stages: index 0 is stage 5, index DIV_STEPS is the output
  logic                    vld_w  [DIV_STEPS+1];
  logic [SCALAR_WIDTH-1:0] scal_w [DIV_STEPS+1];
  logic [SUM_WIDTH-1:0]    den_w  [DIV_STEPS+1];
  tam_div_lane_t           lane_w [DIV_STEPS+1][3];

  // Advance everything when the output register is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Hold the measure mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAJ_MID;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Valid chain of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: capture the beat
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= mode_q;
      maj1_q  <= s_axis_tdata[VW-1:0];
      mid1_q  <= s_axis_tdata[2*VW-1:VW];
      min1_q  <= s_axis_tdata[3*VW-1:2*VW];
    end
  end

  // Stage 2: magnitudes and the scalar modes
  always_comb begin
    // The most negative value maps to 2^(VW-1), still exact unsigned
    amaj = maj1_q[VW-1] ? (~maj1_q + VW'(1)) : maj1_q;
    amid = mid1_q[VW-1] ? (~mid1_q + VW'(1)) : mid1_q;
    amin = min1_q[VW-1] ? (~min1_q + VW'(1)) : min1_q;
    d_mm = {maj1_q[VW-1], maj1_q} - {mid1_q[VW-1], mid1_q};
    d_mn = {maj1_q[VW-1], maj1_q} - {min1_q[VW-1], min1_q};
    unique case (mode1_q)
      MODE_MAJ_MID:  scal2_d = d_mm[SCALAR_WIDTH-1] ? (~d_mm + SCALAR_WIDTH'(1)) : d_mm;
      MODE_MAJ_MIN:  scal2_d = d_mn[SCALAR_WIDTH-1] ? (~d_mn + SCALAR_WIDTH'(1)) : d_mn;
      MODE_ABS_DIFF: scal2_d = {1'b0, amaj} - {1'b0, amin};
      default:       scal2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode2_q <= mode1_q;
      scal2_q <= scal2_d;
      ma2_q   <= amaj;
      mb2_q   <= amid;
      mc2_q   <= amin;
    end
  end

  // Stage 3: sort descending from three parallel compares
  always_comb begin
    ge_ab = (ma2_q >= mb2_q);
    ge_bc = (mb2_q >= mc2_q);
    ge_ac = (ma2_q >= mc2_q);
    hi_d  = ge_ab ? (ge_ac ? ma2_q : mc2_q) : (ge_bc ? mb2_q : mc2_q);
    lo_d  = ge_ab ? (ge_bc ? mc2_q : mb2_q) : (ge_ac ? mc2_q : ma2_q);
    // Max and min are among the three values, so the xor leaves the third
    md_d  = ma2_q ^ mb2_q ^ mc2_q ^ hi_d ^ lo_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode3_q <= mode2_q;
      scal3_q <= scal2_q;
      sa3_q   <= hi_d;
      sb3_q   <= md_d;
      sc3_q   <= lo_d;
    end
  end

  // Stage 4: clamped sum and numerators, zero outside barycentric mode
  always_comb begin
    s4_d = SUM_WIDTH'(sa3_q) + SUM_WIDTH'(sb3_q) + SUM_WIDTH'(sc3_q);
    if (s4_d == '0) begin
      s4_d = SUM_WIDTH'(1);
    end
    if (mode3_q == MODE_BARY) begin
      num4_d[0] = SUM_WIDTH'(sa3_q) - SUM_WIDTH'(sb3_q);
      num4_d[1] = (SUM_WIDTH'(sb3_q) - SUM_WIDTH'(sc3_q)) << 1;
      num4_d[2] = SUM_WIDTH'(sc3_q) + (SUM_WIDTH'(sc3_q) << 1);
    end else begin
      num4_d[0] = '0;
      num4_d[1] = '0;
      num4_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scal4_q <= scal3_q;
      s4_q    <= s4_d;
      num4_q  <= num4_d;
    end
  end

  // Stage 5: leading quotient bit, numerator never exceeds the divisor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (num4_q[k] >= s4_q) begin
        lane5_d[k].rem = num4_q[k] - s4_q;
        lane5_d[k].quo = FRAC_WIDTH'(1);
      end else begin
        lane5_d[k].rem = num4_q[k];
        lane5_d[k].quo = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scal5_q <= scal4_q;
      den5_q  <= s4_q;
      lane5_q <= lane5_d;
    end
  end

  assign vld_w[0]  = v5_q;
  assign scal_w[0] = scal5_q;
  assign den_w[0]  = den5_q;
  for (genvar k = 0; k < 3; k++) begin : g_lane_head
    assign lane_w[0][k] = lane5_q[k];
  end

  // Divider stages: one fraction bit per stage for each lane
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic                    v_q;
    logic [SCALAR_WIDTH-1:0] scal_q;
    logic [SUM_WIDTH-1:0]    den_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= vld_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        scal_q <= scal_w[j];
        den_q  <= den_w[j];
      end
    end

    assign vld_w[j+1]  = v_q;
    assign scal_w[j+1] = scal_q;
    assign den_w[j+1]  = den_q;

    for (genvar k = 0; k < 3; k++) begin : g_lane
      tam_div_step u_step (
        .clk_i  (clk_i),
        .en_i   (en),
        .den_i  (den_w[j]),
        .lane_i (lane_w[j][k]),
        .lane_o (lane_w[j+1][k])
      );
    end
  end

  // Output beat straight from the last divider stage
  assign m_axis_tvalid = vld_w[DIV_STEPS];
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                          lane_w[DIV_STEPS][2].quo,
                          lane_w[DIV_STEPS][1].quo,
                          lane_w[DIV_STEPS][0].quo,
                          scal_w[DIV_STEPS]};

  // A valid beat advancing from the stage before the output always fills the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_w[DIV_STEPS-1] |=> m_axis_tvalid)
    else $error("valid lost between last divider stage and output");

  // Fractions never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (lane_w[DIV_STEPS][0].quo <= FRAC_ONE) &&
                      (lane_w[DIV_STEPS][1].quo <= FRAC_ONE) &&
                      (lane_w[DIV_STEPS][2].quo <= FRAC_ONE))
    else $error("barycentric fraction above one");

  // Scalar and fractions are never both non-zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((lane_w[DIV_STEPS][0].quo != '0) ||
                      (lane_w[DIV_STEPS][1].quo != '0) ||
                      (lane_w[DIV_STEPS][2].quo != '0)) |-> (scal_w[DIV_STEPS] == '0))
    else $error("scalar and fractions both non-zero");

endmodule : tensor_anisotropy_measure

`default_nettype wire

@@ hw/rtl/tam_div_step.sv @@
// ----------------------------------------------------------------------------
// tam_div_step: one registered restoring division step
// Doubles the partial remainder, subtracts the divisor where it fits and
// shifts the new quotient bit in. One stage of the fraction divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_div_step (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [tam_pkg::SUM_WIDTH-1:0] den_i,
  input  wire tam_pkg::tam_div_lane_t        lane_i,
  output tam_pkg::tam_div_lane_t             lane_o
);

  import tam_pkg::*;

  logic [SUM_WIDTH:0]    trial;
  logic [SUM_WIDTH:0]    diff;
  logic                  fits;
  tam_div_lane_t         lane_d;
  tam_div_lane_t         lane_q;

  // Shift, trial subtract, restore on borrow
  always_comb begin
    trial       = {lane_i.rem, 1'b0};
    diff        = trial - {1'b0, den_i};
    fits        = (trial >= {1'b0, den_i});
    lane_d.rem  = fits ? diff[SUM_WIDTH-1:0] : trial[SUM_WIDTH-1:0];
    lane_d.quo  = {lane_i.quo[FRAC_WIDTH-2:0], fits};
  end

  // Payload register, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule : tam_div_step

`default_nettype wire
